/* sv/tetm_pkg.sv */
// Shared types and constants of the task execution time monitor.
`timescale 1ns / 1ps

package tetm_pkg;

	localparam int TASKS_DEF       = 8;
	localparam int TRACE_DEPTH_DEF = 49;

	localparam int TASK_REQ_W  = 3;
	localparam int TIME_W      = 32;
	localparam int SLOT_W      = 6;
	localparam int NEST_W      = 8;
	localparam int PEAK_W      = 7;
	localparam int ENTRY_W     = 4;

	localparam int IN_DATA_W   = 48;
	localparam int IN_USER_W   = 2;
	localparam int OUT_DATA_W  = 88;

	typedef enum logic [1:0] {
		OP_START      = 2'd0,
		OP_STOP       = 2'd1,
		OP_READ_STATS = 2'd2,
		OP_READ_TRACE = 2'd3
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

/* sv/task_execution_time_monitor.sv */
// Task execution time monitor: start/stop profiling, worst-case times and event trace.
`timescale 1ns / 1ps

// Each beat on the slave side carries one event: start or stop of a task, a read of a
// task's worst time, or a read of one trace word counted from the oldest slot. Every
// event gives exactly one result beat. An event is handled in two steps: one reads the
// synchronous task table and trace ring, one computes, writes back and loads the output
// register once it is free; the next event is taken while a result still waits to be taken.
// All tables read as zero after reset through per-entry valid bits, so no clearing
// pass is needed and events are accepted as soon as reset is released.
module task_execution_time_monitor #(
	parameter int TASKS       = tetm_pkg::TASKS_DEF,
	parameter int TRACE_DEPTH = tetm_pkg::TRACE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// task_req [2:0], now_ms [34:3], trace_slot [40:35], zero fill above
	input  logic [tetm_pkg::IN_DATA_W-1:0]  s_tdata,
	// operation [1:0]
	input  logic [tetm_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// elapsed_ms [31:0], worst_ms [63:32], nesting [71:64], max_nesting [78:72],
	// trace_entry [82:79], zero fill above
	output logic [tetm_pkg::OUT_DATA_W-1:0] m_tdata
);
	import tetm_pkg::*;

	localparam int TASK_AW = (TASKS > 1) ? $clog2(TASKS) : 1;
	localparam int TR_AW   = $clog2(TRACE_DEPTH);
	localparam int RED_W   = 15;

	// Input fields
	logic [TASK_REQ_W-1:0] in_task;
	logic [TIME_W-1:0]     in_now;
	logic [SLOT_W-1:0]     in_slot;
	op_t                   in_op;
	logic [6:0]            in_id_ext;
	logic                  in_ok;
	logic [TASK_AW-1:0]    in_idx;

	assign in_task   = s_tdata[2:0];
	assign in_now    = s_tdata[34:3];
	assign in_slot   = s_tdata[40:35];
	assign in_op     = op_t'(s_tuser);
	assign in_id_ext = {4'b0000, in_task};
	assign in_ok     = (in_id_ext < 7'(TASKS));
	assign in_idx    = in_id_ext[TASK_AW-1:0];

	// Control
	state_t state_q, state_nxt;
	logic   accept;
	logic   exec_go;
	logic   m_tvalid_q;

	assign accept = s_tvalid && s_tready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_nxt = ST_EXEC;
			ST_EXEC: if (!m_tvalid_q || m_tready) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		exec_go  = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_EXEC: exec_go  = !m_tvalid_q || m_tready;
			default: begin
				s_tready = 1'b0;
				exec_go  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Trace read address: slot reduced modulo the ring depth, then offset from the oldest entry.
	logic [TR_AW-1:0] trace_pos_q;
	logic [TR_AW-1:0] rd_slot;
	logic [TR_AW:0]   rd_sum;
	logic [TR_AW-1:0] rd_addr;

	always_comb begin
		logic [RED_W-1:0] rem;
		logic [RED_W-1:0] sub;
		rem = {{(RED_W-SLOT_W){1'b0}}, in_slot};
		for (int k = SLOT_W - 1; k >= 0; k--) begin
			sub = RED_W'(TRACE_DEPTH) << k;
			if (rem >= sub) rem = rem - sub;
		end
		rd_slot = rem[TR_AW-1:0];
		rd_sum  = {1'b0, trace_pos_q} + {1'b0, rd_slot};
		if (rd_sum >= (TR_AW+1)'(TRACE_DEPTH)) rd_sum = rd_sum - (TR_AW+1)'(TRACE_DEPTH);
		rd_addr = rd_sum[TR_AW-1:0];
	end

	// Memories and their valid bits; a task entry holds the worst time above the start stamp.
	logic [2*TIME_W-1:0]    task_mem [TASKS];
	logic [ENTRY_W-1:0]     ring_mem [TRACE_DEPTH];
	logic [TASKS-1:0]       task_vld_q;
	logic [TRACE_DEPTH-1:0] ring_vld_q;

	// Item captured at accept and read data
	op_t                 op_s1;
	logic                ok_s1;
	logic [TASK_AW-1:0]  idx_s1;
	logic [ENTRY_W-1:0]  id_s1;
	logic [TIME_W-1:0]   now_s1;
	logic [2*TIME_W-1:0] task_rd_s1;
	logic [ENTRY_W-1:0]  ring_rd_s1;
	logic                task_vld_s1;
	logic                ring_vld_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= in_op;
			ok_s1      <= in_ok;
			idx_s1     <= in_idx;
			id_s1      <= {1'b0, in_task};
			now_s1     <= in_now;
			task_rd_s1 <= task_mem[in_idx];
			ring_rd_s1 <= ring_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_vld_s1 <= 1'b0;
			ring_vld_s1 <= 1'b0;
		end else if (accept) begin
			task_vld_s1 <= task_vld_q[in_idx];
			ring_vld_s1 <= ring_vld_q[rd_addr];
		end
	end

	// Execute: compute the result and the write-back
	logic signed [NEST_W-1:0] nest_q;
	logic [PEAK_W-1:0]        peak_q;
	logic [TIME_W-1:0]        stamp_val;
	logic [TIME_W-1:0]        worst_val;
	logic [TIME_W-1:0]        elapsed_c;
	logic signed [NEST_W-1:0] nest_nxt;
	logic [PEAK_W-1:0]        peak_nxt;
	logic [TIME_W-1:0]        elapsed_out;
	logic [TIME_W-1:0]        worst_out;
	logic [ENTRY_W-1:0]       entry_out;
	logic                     stamp_we;
	logic                     worst_we;
	logic                     ring_we;
	logic [ENTRY_W-1:0]       ring_wdata;
	logic [2*TIME_W-1:0]      task_wdata;
	logic [7:0]               word_start;
	logic [7:0]               word_stop;

	assign stamp_val  = task_vld_s1 ? task_rd_s1[TIME_W-1:0] : '0;
	assign worst_val  = task_vld_s1 ? task_rd_s1[2*TIME_W-1:TIME_W] : '0;
	assign elapsed_c  = now_s1 - stamp_val;
	assign word_start = 8'(TASKS) + {4'b0000, id_s1};
	assign word_stop  = 8'(TASKS) - {4'b0000, id_s1};
	assign task_wdata = {(worst_we ? elapsed_c : worst_val), (stamp_we ? now_s1 : stamp_val)};

	always_comb begin
		nest_nxt    = nest_q;
		peak_nxt    = peak_q;
		elapsed_out = '0;
		worst_out   = ok_s1 ? worst_val : '0;
		entry_out   = '0;
		stamp_we    = 1'b0;
		worst_we    = 1'b0;
		ring_we     = 1'b0;
		ring_wdata  = word_start[ENTRY_W-1:0];
		case (op_s1)
			OP_START: begin
				if (ok_s1) begin
					if (nest_q != 8'sd127) nest_nxt = nest_q + 8'sd1;
					stamp_we = 1'b1;
					ring_we  = 1'b1;
				end
			end
			OP_STOP: begin
				if (ok_s1) begin
					elapsed_out = elapsed_c;
					if (elapsed_c > worst_val) begin
						worst_we  = 1'b1;
						worst_out = elapsed_c;
					end
					if (nest_q != -8'sd128) nest_nxt = nest_q - 8'sd1;
					// The peak follows the count after it has been lowered.
					if (nest_nxt > $signed({1'b0, peak_q})) peak_nxt = nest_nxt[PEAK_W-1:0];
					ring_we    = 1'b1;
					ring_wdata = word_stop[ENTRY_W-1:0];
				end
			end
			OP_READ_TRACE: begin
				worst_out = '0;
				entry_out = ring_vld_s1 ? ring_rd_s1 : '0;
			end
			default: begin
				worst_out = ok_s1 ? worst_val : '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (exec_go && (stamp_we || worst_we)) task_mem[idx_s1] <= task_wdata;
		if (exec_go && ring_we) ring_mem[trace_pos_q] <= ring_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_vld_q  <= '0;
			ring_vld_q  <= '0;
			trace_pos_q <= '0;
			nest_q      <= '0;
			peak_q      <= '0;
		end else if (exec_go) begin
			if (stamp_we || worst_we) task_vld_q[idx_s1] <= 1'b1;
			if (ring_we) begin
				ring_vld_q[trace_pos_q] <= 1'b1;
				if (trace_pos_q == TR_AW'(TRACE_DEPTH - 1)) trace_pos_q <= '0;
				else trace_pos_q <= trace_pos_q + TR_AW'(1);
			end
			nest_q <= nest_nxt;
			peak_q <= peak_nxt;
		end
	end

	// Output register
	logic [TIME_W-1:0]  elapsed_q;
	logic [TIME_W-1:0]  worst_q;
	logic [NEST_W-1:0]  nesting_q;
	logic [PEAK_W-1:0]  max_nest_q;
	logic [ENTRY_W-1:0] entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (exec_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			elapsed_q  <= elapsed_out;
			worst_q    <= worst_out;
			nesting_q  <= nest_nxt;
			max_nest_q <= peak_nxt;
			entry_q    <= entry_out;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b00000, entry_q, max_nest_q, nesting_q, worst_q, elapsed_q};

endmodule

/* sim/task_execution_time_monitor_tb.sv */
// Self-checking testbench for the task execution time monitor.
`timescale 1ns / 1ps

module task_execution_time_monitor_tb;
	import tetm_pkg::*;

	localparam int TASKS        = TASKS_DEF;
	localparam int DEPTH        = TRACE_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1750;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [TIME_W-1:0]  elapsed;
		logic [TIME_W-1:0]  worst;
		logic [NEST_W-1:0]  nesting;
		logic [PEAK_W-1:0]  peak;
		logic [ENTRY_W-1:0] entry;
	} result_t;

	typedef struct {
		op_t                   op;
		logic [TASK_REQ_W-1:0] id;
		logic [TIME_W-1:0]     now;
		logic [SLOT_W-1:0]     slot;
		bit                    known;
		result_t               res;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [IN_USER_W-1:0]  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	task_execution_time_monitor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Predicted copy of the profiling state.
	logic [TIME_W-1:0]         stamp_tbl [TASKS];
	logic [TIME_W-1:0]         worst_tbl [TASKS];
	logic signed [NEST_W-1:0]  nest_now;
	logic [PEAK_W-1:0]         nest_max;
	logic [ENTRY_W-1:0]        ring [DEPTH];
	int                        wr_pos;

	result_t   pending_results [$];
	stim_row_t dir_tbl [$];
	int        errors;
	int        items_sent;
	bit        no_gaps;
	bit        rx_free;
	bit        pressure_req;

	function automatic result_t predict_profile(op_t op, logic [TASK_REQ_W-1:0] id,
			logic [TIME_W-1:0] now, logic [SLOT_W-1:0] slot);
		result_t r;
		int      idx;
		r   = '0;
		idx = int'(id);
		case (op)
			OP_START: begin
				if (idx < TASKS) begin
					if (nest_now != 8'h7F)
						nest_now = nest_now + 8'sd1;
					stamp_tbl[idx] = now;
					ring[wr_pos]   = 4'((TASKS + idx) & 15);
					wr_pos         = (wr_pos + 1) % DEPTH;
				end
			end
			OP_STOP: begin
				if (idx < TASKS) begin
					r.elapsed = now - stamp_tbl[idx];
					if (r.elapsed > worst_tbl[idx])
						worst_tbl[idx] = r.elapsed;
					if (nest_now != 8'h80)
						nest_now = nest_now - 8'sd1;
					// The peak follows the count after it has been lowered.
					if (int'(nest_now) > int'(nest_max))
						nest_max = nest_now[PEAK_W-1:0];
					ring[wr_pos] = 4'((TASKS - idx) & 15);
					wr_pos       = (wr_pos + 1) % DEPTH;
				end
			end
			OP_READ_TRACE: begin
				r.entry = ring[(wr_pos + int'(slot) % DEPTH) % DEPTH];
			end
			default: ;
		endcase
		if (op != OP_READ_TRACE && idx < TASKS)
			r.worst = worst_tbl[idx];
		r.nesting = nest_now;
		r.peak    = nest_max;
		return r;
	endfunction

	function automatic result_t mk_res(logic [31:0] e, logic [31:0] w, logic [7:0] n,
			logic [6:0] p, logic [3:0] t);
		result_t r;
		r.elapsed = e;
		r.worst   = w;
		r.nesting = n;
		r.peak    = p;
		r.entry   = t;
		return r;
	endfunction

	function automatic void add_row(op_t op, int id, logic [31:0] now, int slot, bit known,
			result_t res);
		stim_row_t row;
		row.op    = op;
		row.id    = id[TASK_REQ_W-1:0];
		row.now   = now;
		row.slot  = slot[SLOT_W-1:0];
		row.known = known;
		row.res   = res;
		dir_tbl.push_back(row);
	endfunction

	function automatic int tx_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_event(op_t op, logic [TASK_REQ_W-1:0] id, logic [TIME_W-1:0] now,
			logic [SLOT_W-1:0] slot, bit known, result_t known_res);
		int      n;
		result_t r;
		n = tx_gap();
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		r = predict_profile(op, id, now, slot);
		if (known)
			r = known_res;
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, slot, now, id};
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(r);
		items_sent++;
	endtask

	task automatic send_noise();
		op_t op;
		op = op_t'($urandom_range(0, 3));
		send_event(op, TASK_REQ_W'($urandom_range(0, 7)), $urandom,
			SLOT_W'($urandom_range(0, 63)), 1'b0, '0);
	endtask

	task automatic send_trace_read();
		int slot;
		slot = ($urandom_range(0, 7) == 0) ? $urandom_range(49, 63) : $urandom_range(0, 48);
		send_event(OP_READ_TRACE, 0, $urandom, SLOT_W'(slot), 1'b0, '0);
	endtask

	// Properly nested start/stop pairs with increasing timestamps.
	task automatic send_nested_run();
		logic [TASK_REQ_W-1:0] ids [8];
		logic [TIME_W-1:0]     t;
		int                    depth;
		depth = $urandom_range(1, 6);
		t     = $urandom;
		for (int k = 0; k < depth; k++) begin
			ids[k] = TASK_REQ_W'($urandom_range(0, 7));
			t      = t + $urandom_range(0, 50);
			send_event(OP_START, ids[k], t, SLOT_W'($urandom_range(0, 63)), 1'b0, '0);
		end
		for (int k = depth - 1; k >= 0; k--) begin
			if ($urandom_range(0, 5) == 0)
				send_event(OP_READ_STATS, TASK_REQ_W'($urandom_range(0, 7)), $urandom, 0,
					1'b0, '0);
			if ($urandom_range(0, 9) == 0)
				t = t + $urandom_range(0, 2000000);
			else
				t = t + $urandom_range(0, 300);
			send_event(OP_STOP, ids[k], t, SLOT_W'($urandom_range(0, 63)), 1'b0, '0);
		end
	endtask

	// Drive the nesting count to both saturation limits and back to zero.
	task automatic send_saturation();
		while (nest_now != 8'h7F)
			send_event(OP_START, TASK_REQ_W'($urandom_range(0, 7)), $urandom, 0, 1'b0, '0);
		repeat (3)
			send_event(OP_START, TASK_REQ_W'($urandom_range(0, 7)), $urandom, 0, 1'b0, '0);
		send_event(OP_READ_STATS, TASK_REQ_W'($urandom_range(0, 7)), 0, 0, 1'b0, '0);
		while (nest_now != 8'h80)
			send_event(OP_STOP, TASK_REQ_W'($urandom_range(0, 7)), $urandom, 0, 1'b0, '0);
		repeat (3)
			send_event(OP_STOP, TASK_REQ_W'($urandom_range(0, 7)), $urandom, 0, 1'b0, '0);
		send_trace_read();
		while (nest_now != 8'h00)
			send_event(OP_START, TASK_REQ_W'($urandom_range(0, 7)), $urandom, 0, 1'b0, '0);
	endtask

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
			errors++;
		end
	endfunction

	// Result side: random back-pressure, plus one long hold-off on request.
	initial begin
		int r;
		int n;
		forever begin
			if (pressure_req) begin
				pressure_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (rx_free || r < 65) begin
					m_tready <= 1'b1;
					@(posedge clk);
				end else begin
					n = (r < 95) ? $urandom_range(1, 4) : $urandom_range(15, 50);
					m_tready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	initial begin
		result_t exp_r;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("result beat with no pending event: %h", m_tdata);
					errors++;
				end else begin
					exp_r = pending_results.pop_front();
					check_field("elapsed_ms", exp_r.elapsed, m_tdata[31:0]);
					check_field("worst_ms", exp_r.worst, m_tdata[63:32]);
					check_field("nesting", 32'(exp_r.nesting), 32'(m_tdata[71:64]));
					check_field("max_nesting", 32'(exp_r.peak), 32'(m_tdata[78:72]));
					check_field("trace_entry", 32'(exp_r.entry), 32'(m_tdata[82:79]));
				end
			end
		end
	end

	initial begin
		#8000000;
		$display("task_execution_time_monitor_tb: FAIL");
		$finish;
	end

	initial begin
		int  kind;
		int  target;
		bit  pressure_done;
		bit  saturation_done;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		errors       = 0;
		items_sent   = 0;
		no_gaps      = 1'b0;
		rx_free      = 1'b0;
		pressure_req = 1'b0;
		pressure_done   = 1'b0;
		saturation_done = 1'b0;
		for (int i = 0; i < TASKS; i++) begin
			stamp_tbl[i] = '0;
			worst_tbl[i] = '0;
		end
		for (int i = 0; i < DEPTH; i++)
			ring[i] = '0;
		nest_now = '0;
		nest_max = '0;
		wr_pos   = 0;

		// Cleared tables first, then timestamp extremes and wrap-around.
		add_row(OP_READ_STATS, 0, 32'h0, 0, 1'b1, mk_res(0, 0, 0, 0, 0));
		add_row(OP_READ_STATS, 7, 32'hFFFFFFFF, 0, 1'b1, mk_res(0, 0, 0, 0, 0));
		add_row(OP_READ_TRACE, 0, 32'h0, 0, 1'b1, mk_res(0, 0, 0, 0, 0));
		add_row(OP_READ_TRACE, 7, 32'h0, 63, 1'b1, mk_res(0, 0, 0, 0, 0));
		add_row(OP_START, 0, 32'h0, 0, 1'b1, mk_res(0, 0, 1, 0, 0));
		add_row(OP_STOP, 0, 32'hFFFFFFFF, 63, 1'b1,
			mk_res(32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0));
		add_row(OP_START, 7, 32'hFFFFFFFF, 0, 1'b1, mk_res(0, 0, 1, 0, 0));
		add_row(OP_STOP, 7, 32'h0, 0, 1'b1, mk_res(1, 1, 0, 0, 0));
		add_row(OP_READ_TRACE, 0, 32'h0, 48, 1'b0, '0);
		add_row(OP_READ_TRACE, 0, 32'h0, 45, 1'b0, '0);
		add_row(OP_READ_TRACE, 0, 32'h0, 0, 1'b0, '0);
		add_row(OP_START, 3, 32'd100, 0, 1'b0, '0);
		add_row(OP_START, 5, 32'd150, 0, 1'b0, '0);
		add_row(OP_STOP, 5, 32'd200, 0, 1'b0, '0);
		add_row(OP_STOP, 3, 32'd400, 0, 1'b0, '0);
		add_row(OP_READ_STATS, 3, 32'h0, 0, 1'b0, '0);
		add_row(OP_READ_STATS, 5, 32'h0, 0, 1'b0, '0);
		add_row(OP_STOP, 2, 32'd12345, 0, 1'b0, '0);
		add_row(OP_START, 6, 32'hAAAAAAAA, 21, 1'b0, '0);
		add_row(OP_STOP, 6, 32'h55555555, 42, 1'b0, '0);
		add_row(OP_READ_TRACE, 0, 32'h0, 49, 1'b0, '0);
		add_row(OP_READ_TRACE, 0, 32'h0, 62, 1'b0, '0);
		add_row(OP_READ_STATS, 6, 32'h0, 0, 1'b0, '0);
		add_row(OP_START, 1, 32'h80000000, 0, 1'b0, '0);
		add_row(OP_STOP, 1, 32'h7FFFFFFF, 0, 1'b0, '0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tbl[i])
			send_event(dir_tbl[i].op, dir_tbl[i].id, dir_tbl[i].now, dir_tbl[i].slot,
				dir_tbl[i].known, dir_tbl[i].res);

		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			rx_free = ($urandom_range(0, 4) == 0);
			if (!pressure_done && items_sent >= 400) begin
				// Keep offering beats while the result side holds off.
				no_gaps      = 1'b1;
				rx_free      = 1'b0;
				pressure_req = 1'b1;
				repeat (60) send_noise();
				pressure_done = 1'b1;
			end else if (!saturation_done && items_sent >= 1200) begin
				send_saturation();
				saturation_done = 1'b1;
			end else begin
				kind = $urandom_range(0, 9);
				if (kind < 6) begin
					send_nested_run();
				end else if (kind < 8) begin
					repeat ($urandom_range(1, 10)) send_noise();
				end else if (kind == 8) begin
					repeat ($urandom_range(1, 6)) send_trace_read();
				end else begin
					repeat ($urandom_range(1, 4))
						send_event(OP_READ_STATS, TASK_REQ_W'($urandom_range(0, 7)),
							$urandom, SLOT_W'($urandom_range(0, 63)), 1'b0, '0);
				end
			end
		end
		s_tvalid <= 1'b0;
		rx_free = 1'b1;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("task_execution_time_monitor_tb: PASS");
		else
			$display("task_execution_time_monitor_tb: FAIL");
		$finish;
	end

endmodule

/* files.f */
sv/tetm_pkg.sv
sv/task_execution_time_monitor.sv
sim/task_execution_time_monitor_tb.sv
